### design/mpp_pkg.sv
// ----------------------------------------------------------------------------
// mpp_pkg
// Shared types, constants and the residue table of the modular product PRNG.
// ----------------------------------------------------------------------------
`default_nettype none

package mpp_pkg;

  localparam int WORD_W     = 32;
  localparam int PROD_W     = 2 * WORD_W;
  localparam int STATE_BITS = 32;
  localparam int IDX_W      = 6;   // table index 0..STATE_BITS
  localparam int FOLD_W     = 24;  // width of FOLD_C

  // Prime modulus, and 2^32 mod P, which is used to fold the high word down.
  localparam logic [WORD_W-1:0] PRIME_P = 32'd4279969613;
  localparam logic [FOLD_W-1:0] FOLD_C  = 24'd14997683;

  // Transaction kinds on the input channel.
  localparam logic KIND_GEN  = 1'b0;
  localparam logic KIND_SEED = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_FOLD
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INIT,
    OP_MUL,
    OP_FOLD,
    OP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] idx;
  } dp_ctrl_t;

  typedef struct packed {
    logic              hi_zero;
    logic [WORD_W-1:0] acc;
  } dp_stat_t;

  function automatic logic [WORD_W-1:0] residue(input logic [IDX_W-1:0] i);
    logic [WORD_W-1:0] r;
    case (i)
      6'd0:    r = 32'd2737981618;
      6'd1:    r = 32'd1080320388;
      6'd2:    r = 32'd1723072060;
      6'd3:    r = 32'd4228301455;
      6'd4:    r = 32'd4149129801;
      6'd5:    r = 32'd3571453456;
      6'd6:    r = 32'd2502499170;
      6'd7:    r = 32'd2645177746;
      6'd8:    r = 32'd1174113779;
      6'd9:    r = 32'd460790047;
      6'd10:   r = 32'd2432060459;
      6'd11:   r = 32'd3642283025;
      6'd12:   r = 32'd2171537408;
      6'd13:   r = 32'd1964923279;
      6'd14:   r = 32'd167928637;
      6'd15:   r = 32'd764994146;
      6'd16:   r = 32'd33580906;
      6'd17:   r = 32'd152749582;
      6'd18:   r = 32'd3155509836;
      6'd19:   r = 32'd1068833496;
      6'd20:   r = 32'd3292407144;
      6'd21:   r = 32'd686219412;
      6'd22:   r = 32'd550755449;
      6'd23:   r = 32'd1072869831;
      6'd24:   r = 32'd2507702675;
      6'd25:   r = 32'd2920217274;
      6'd26:   r = 32'd2456957004;
      6'd27:   r = 32'd3987169726;
      6'd28:   r = 32'd3828720855;
      6'd29:   r = 32'd2539518588;
      6'd30:   r = 32'd420287618;
      6'd31:   r = 32'd2009403111;
      6'd32:   r = 32'd1732156098;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### design/mpp_in_if.sv
// ----------------------------------------------------------------------------
// mpp_in_if
// Input channel: generate or reseed transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpp_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] seed;

  modport source (output valid, output kind, output seed, input ready);
  modport sink   (input valid, input kind, input seed, output ready);
endinterface

`default_nettype wire

### design/mpp_out_if.sv
// ----------------------------------------------------------------------------
// mpp_out_if
// Result channel: one generated word per generate transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

### design/mpp_mulred.sv
// ----------------------------------------------------------------------------
// mpp_mulred
// Shared multiply-add unit with product register and running accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module mpp_mulred (
  input  wire logic          clk,
  input  wire mpp_pkg::dp_ctrl_t ctrl,
  output mpp_pkg::dp_stat_t  stat
);
  import mpp_pkg::*;

  logic [WORD_W-1:0] acc_r;
  logic [PROD_W-1:0] prod_r;

  logic [WORD_W-1:0] mul_a;
  logic [WORD_W-1:0] mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [PROD_W-1:0] addend;
  logic [PROD_W-1:0] sum;
  logic [WORD_W-1:0] lo;
  logic [WORD_W-1:0] fin;

  // A fold replaces hi*2^32 + lo by hi*(2^32 mod P) + lo, which keeps the
  // residue and shrinks the high word until it is zero.
  always_comb begin
    if (ctrl.op == OP_MUL) begin
      mul_a  = acc_r;
      mul_b  = residue(ctrl.idx);
      addend = '0;
    end else begin
      mul_a  = prod_r[PROD_W-1:WORD_W];
      mul_b  = {{(WORD_W-FOLD_W){1'b0}}, FOLD_C};
      addend = {{WORD_W{1'b0}}, prod_r[WORD_W-1:0]};
    end
    mul_p = {{WORD_W{1'b0}}, mul_a} * {{WORD_W{1'b0}}, mul_b};
    sum   = mul_p + addend;
    lo    = prod_r[WORD_W-1:0];
    // With the high word gone the value is below 2^32, hence below 2P.
    fin   = (lo >= PRIME_P) ? (lo - PRIME_P) : lo;
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_INIT: acc_r  <= residue('0);
      OP_MUL:  prod_r <= sum;
      OP_FOLD: prod_r <= sum;
      OP_FIN:  acc_r  <= fin;
      default: ;
    endcase
  end

  assign stat = '{hi_zero: (prod_r[PROD_W-1:WORD_W] == '0), acc: acc_r};

endmodule

`default_nettype wire

### design/mpp_ctrl.sv
// ----------------------------------------------------------------------------
// mpp_ctrl
// Sequencer: handshakes, state word, bit scan and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mpp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  mpp_in_if.sink             in_ch,
  mpp_out_if.source          out_ch,
  output mpp_pkg::dp_ctrl_t  ctrl,
  input  wire mpp_pkg::dp_stat_t stat
);
  import mpp_pkg::*;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  bit_r;
  logic [WORD_W-1:0] word_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_value_r;

  logic in_acc;
  logic scan_done;
  logic out_free;
  logic emit;
  logic bit_inc;
  logic in_ready;

  assign in_acc    = in_ch.valid && in_ready;
  assign scan_done = (bit_r == IDX_W'(STATE_BITS));
  assign out_free  = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_ch.kind == KIND_GEN) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) begin
          if (out_free) state_nxt = ST_IDLE;
        end else if (word_r[bit_r[IDX_W-2:0]]) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_FOLD;
      ST_FOLD: begin
        if (stat.hi_zero) state_nxt = ST_SCAN;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ctrl.op  = OP_HOLD;
    ctrl.idx = bit_r + IDX_W'(1);
    emit     = 1'b0;
    bit_inc  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid && in_ch.kind == KIND_GEN) ctrl.op = OP_INIT;
      end
      ST_SCAN: begin
        if (scan_done) emit = out_free;
        else bit_inc = !word_r[bit_r[IDX_W-2:0]];
      end
      ST_MUL:  ctrl.op = OP_MUL;
      ST_FOLD: begin
        ctrl.op = stat.hi_zero ? OP_FIN : OP_FOLD;
        bit_inc = stat.hi_zero;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      word_r      <= '0;
      bit_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (in_acc && in_ch.kind == KIND_SEED) word_r <= in_ch.seed;
      else if (emit) word_r <= stat.acc;
      if (in_acc) bit_r <= '0;
      else if (bit_inc) bit_r <= bit_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_value_r <= stat.acc;
  end

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.value = out_value_r;

endmodule

`default_nettype wire

### design/modular_product_prng.sv
// ----------------------------------------------------------------------------
// modular_product_prng
// Naor-Reingold style word generator built on products modulo a 32-bit prime.
// ----------------------------------------------------------------------------
// The input channel in_ch carries kind and seed. A reseed transaction loads
// the state word and gives no result. A generate transaction starts from
// table entry 0 and, for every set bit i of the state, multiplies by table
// entry i+1 modulo P; the result leaves on out_ch and becomes the new
// state.
// One 32x32 multiplier is shared for the table products and for folding the
// high product word down (by 2^32 mod P). The sequencer scans the state
// bits in order; for each set bit it runs a multiply step, then folds while
// the high word is nonzero and finishes with a final correction step.
// in_ch is not ready while a generate runs.
// The result sits in an output register; the next transaction is accepted
// while it waits. If out_ch stalls, a following generate finishes its scan
// and holds until the register frees up.
// Synchronous reset clears the state word to zero and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_product_prng (
  input  wire logic clk,
  input  wire logic rst_n,
  mpp_in_if.sink    in_ch,
  mpp_out_if.source out_ch
);
  import mpp_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  mpp_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .ctrl   (ctrl),
    .stat   (stat)
  );

  mpp_mulred u_mulred (
    .clk  (clk),
    .ctrl (ctrl),
    .stat (stat)
  );

  // The corrected accumulator is always a proper residue.
  a_fin_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.op == OP_FIN |=> stat.acc < PRIME_P)
    else $error("accumulator not reduced below P");

  // A multiply is always followed by folding of its product.
  a_mul_then_fold: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.op == OP_MUL |=> ctrl.op == OP_FOLD || ctrl.op == OP_FIN)
    else $error("multiply not followed by reduction");

  // A generate transaction makes the block busy at once.
  a_gen_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.kind == KIND_GEN |=> !in_ch.ready)
    else $error("input ready while generating");

endmodule

`default_nettype wire
